/* src/lockout_rate_spike_detector_core_assert.svh */
// Assertion macros used by the lockout rate spike detector core.
`ifndef LOCKOUT_RATE_SPIKE_DETECTOR_CORE_ASSERT_SVH
`define LOCKOUT_RATE_SPIKE_DETECTOR_CORE_ASSERT_SVH

// Clocked assertion, switched off while the asynchronous reset is held.
`define LRSD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("lrsd assertion failed");

// Clocked check that a condition never holds outside reset.
`define LRSD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("lrsd forbidden condition seen");

`endif

/* src/lrsd_pkg.sv */
// Shared constants and types of the lockout rate spike detector.
package lrsd_pkg;

  localparam int unsigned RING_DEPTH        = 256;
  localparam int unsigned DEFAULT_THRESHOLD = 10;
  localparam int unsigned DEFAULT_WINDOW    = 60;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned THR_W  = 10;
  localparam int unsigned WIN_W  = 32;
  localparam int unsigned OUT_W  = 9;
  localparam int unsigned SHOWN_MAX = (1 << OUT_W) - 1;

  localparam int unsigned IDX_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WINDOW    = 2'd1,
    CFG_ENABLE    = 2'd2
  } cfg_idx_e;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [CNT_W-1:0]  cnt_t;

endpackage

/* src/lockout_rate_spike_detector_core.sv */
// Top level of the lockout rate spike detector: cell ring, scan control, output word.
//
// Input channel (in_valid_i / in_ready_o) takes one word per lockout event,
// its time stamp in seconds. The stamp is shifted into a chain of 256 cells,
// dropping the oldest entry once the chain is full. The chain then rotates
// once round, one cell per cycle, and the tail cell passes a single window
// comparator and hit counter.
// Output channel (out_valid_o / out_ready_i) returns one word per event:
// crossed, alert and events_in_window.
// The count is loaded into the output register from the hold state after the
// rotation; a new event is accepted only once that load has happened.
// The result sits in an output register, so the next event is taken while
// that word still waits. If the receiver stalls longer, the finished count
// waits in the hit counter and no further event is accepted.
// The user writes configuration through cfg_we_i / cfg_idx_i / cfg_wdata_i only
// while the block is idle, which it does not enforce; zero threshold or window
// selects the built-in default. Reset empties the ring at once by clearing every
// valid bit, disarms the detector and clears control state; no clearing pass is needed.
module lockout_rate_spike_detector_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lrsd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lrsd_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [lrsd_pkg::TIME_W-1:0]      event_time_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             crossed_o,
  output logic                             alert_o,
  output logic [lrsd_pkg::OUT_W-1:0]       events_in_window_o
);
  import lrsd_pkg::*;

  `include "lockout_rate_spike_detector_core_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [THR_W-1:0] thr_q;
  logic [WIN_W-1:0] win_q;
  logic             alert_en_q;

  logic [THR_W-1:0] thr_eff;
  logic [WIN_W-1:0] win_eff;

  time_t            now_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             armed_q, armed_d;

  logic             out_valid_q, out_valid_d;
  logic             crossed_q, alert_q;
  logic [OUT_W-1:0] events_q;

  logic in_acc, scanning, shift, last_step, load;

  time_t           cell_time [RING_DEPTH];
  logic [RING_DEPTH-1:0] cell_vld;

  cnt_t             cnt;
  logic [OUT_W-1:0] shown;
  logic             reached, cross_now;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= '0;
      win_q      <= '0;
      alert_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD: thr_q      <= cfg_wdata_i[THR_W-1:0];
        CFG_WINDOW:    win_q      <= cfg_wdata_i[WIN_W-1:0];
        CFG_ENABLE:    alert_en_q <= cfg_wdata_i[0];
        default:       ;
      endcase
    end
  end

  assign thr_eff = (thr_q == '0) ? THR_W'(DEFAULT_THRESHOLD) : thr_q;
  assign win_eff = (win_q == '0) ? WIN_W'(DEFAULT_WINDOW) : win_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign scanning   = (state_q == ST_SCAN);
  assign shift      = in_acc || scanning;
  assign last_step  = scanning && (idx_q == IDX_W'(RING_DEPTH - 1));
  assign load       = (state_q == ST_HOLD) && (!out_valid_q || out_ready_i);

  // The head cell takes the new stamp on acceptance and the tail while rotating.
  for (genvar k = 0; k < RING_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      lrsd_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .time_i  (in_acc ? event_time_i : cell_time[RING_DEPTH-1]),
        .valid_i (in_acc ? 1'b1 : cell_vld[RING_DEPTH-1]),
        .time_o  (cell_time[k]),
        .valid_o (cell_vld[k])
      );
    end else begin : g_body
      lrsd_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .time_i  (cell_time[k-1]),
        .valid_i (cell_vld[k-1]),
        .time_o  (cell_time[k]),
        .valid_o (cell_vld[k])
      );
    end
  end

  lrsd_counter u_counter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (in_acc),
    .en_i        (scanning),
    .now_i       (now_q),
    .win_i       (win_eff),
    .ent_time_i  (cell_time[RING_DEPTH-1]),
    .ent_valid_i (cell_vld[RING_DEPTH-1]),
    .count_o     (cnt)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q <= event_time_i;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_SCAN;
          idx_d   = '0;
        end
      end
      ST_SCAN: begin
        idx_d = idx_q + IDX_W'(1);
        if (last_step) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign reached   = (CMP_W'(cnt) >= CMP_W'(thr_eff));
  assign cross_now = reached && !armed_q;

  always_comb begin
    armed_d = armed_q;
    if (load) begin
      armed_d = reached;
    end
  end

  if (CNT_W > OUT_W) begin : g_sat
    assign shown = (cnt > CNT_W'(SHOWN_MAX)) ? OUT_W'(SHOWN_MAX) : cnt[OUT_W-1:0];
  end else begin : g_nosat
    assign shown = OUT_W'(cnt);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      armed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      armed_q     <= armed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      crossed_q <= cross_now;
      alert_q   <= cross_now && alert_en_q;
      events_q  <= shown;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign crossed_o          = crossed_q;
  assign alert_o            = alert_q;
  assign events_in_window_o = events_q;

  `LRSD_ASSERT(a_accept_starts_scan, clk_i, rst_ni,
               in_acc |=> (state_q == ST_SCAN) && (idx_q == '0))
  `LRSD_ASSERT(a_scan_ends, clk_i, rst_ni, last_step |=> (state_q == ST_HOLD))
  `LRSD_ASSERT(a_fill_monotonic, clk_i, rst_ni,
               $countones(cell_vld) >= $past($countones(cell_vld)))
  `LRSD_ASSERT_NEVER(a_count_bound, clk_i, rst_ni,
                     out_valid_o && (CNT_W'(events_in_window_o) > CNT_W'(RING_DEPTH)))

endmodule

/* src/lrsd_cell.sv */
// One cell of the event ring: a time stamp and its valid bit, shifted on.
module lrsd_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 shift_i,
  input  lrsd_pkg::time_t      time_i,
  input  logic                 valid_i,
  output lrsd_pkg::time_t      time_o,
  output logic                 valid_o
);
  import lrsd_pkg::*;

  time_t time_q;
  logic  valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      time_q <= time_i;
    end
  end

  assign time_o  = time_q;
  assign valid_o = valid_q;

endmodule

/* src/lrsd_counter.sv */
// Window test and hit counter fed by the tail cell of the ring.
module lrsd_counter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  logic                      en_i,
  input  lrsd_pkg::time_t           now_i,
  input  logic [lrsd_pkg::WIN_W-1:0] win_i,
  input  lrsd_pkg::time_t           ent_time_i,
  input  logic                      ent_valid_i,
  output lrsd_pkg::cnt_t            count_o
);
  import lrsd_pkg::*;

  cnt_t cnt_q, cnt_d;
  logic [TIME_W:0] reach;
  logic            hit;

  // now - entry <= win is the same as now <= entry + win without wrap.
  assign reach = {1'b0, ent_time_i} + {1'b0, win_i};
  assign hit   = ent_valid_i && ({1'b0, now_i} <= reach);

  always_comb begin
    cnt_d = cnt_q;
    if (clear_i) begin
      cnt_d = '0;
    end else if (en_i && hit) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign count_o = cnt_q;

endmodule

/* tb/lockout_rate_spike_detector_core_tb.sv */
// Self-checking testbench of the lockout rate spike detector core.
`timescale 1ns / 1ps

import lrsd_pkg::*;

typedef struct packed {
  logic             crossed;
  logic             alert;
  logic [OUT_W-1:0] in_window;
} alarm_word_t;

class spike_alarm_tracker;
  time_t                  stamps [RING_DEPTH];
  logic [IDX_W-1:0]       next_slot;
  int unsigned            filled;
  bit                     armed;
  logic [THR_W-1:0]       threshold;
  logic [WIN_W-1:0]       window;
  logic                   alert_on;
  alarm_word_t            alarm_words [$];
  int unsigned            fails;

  function new();
    next_slot = '0;
    filled    = 0;
    armed     = 1'b0;
    threshold = '0;
    window    = '0;
    alert_on  = 1'b0;
    fails     = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_THRESHOLD: threshold = data[THR_W-1:0];
      CFG_WINDOW:    window    = data[WIN_W-1:0];
      CFG_ENABLE:    alert_on  = data[0];
      default:       ;
    endcase
  endfunction

  // Records an accepted event and works out the word it must produce.
  function void note_lockout(time_t now);
    int unsigned thr;
    int unsigned hits;
    longint      win;
    alarm_word_t w;
    stamps[next_slot] = now;
    next_slot = next_slot + 1'b1;
    if (filled < RING_DEPTH) filled++;
    thr  = (threshold == 0) ? DEFAULT_THRESHOLD : int'(threshold);
    win  = (window == 0) ? longint'(DEFAULT_WINDOW) : longint'(window);
    hits = 0;
    // Entries newer than the event give a negative difference and so count.
    for (int unsigned i = 0; i < filled; i++) begin
      if (longint'(now) - longint'(stamps[i]) <= win) hits++;
    end
    w.crossed = 1'b0;
    if (hits >= thr && !armed) begin
      armed     = 1'b1;
      w.crossed = 1'b1;
    end else if (hits < thr && armed) begin
      armed = 1'b0;
    end
    w.alert     = w.crossed & alert_on;
    w.in_window = (hits > SHOWN_MAX) ? OUT_W'(SHOWN_MAX) : OUT_W'(hits);
    alarm_words.push_back(w);
  endfunction

  function void check_word(logic crossed, logic alert, logic [OUT_W-1:0] in_window);
    alarm_word_t w;
    if (alarm_words.size() == 0) begin
      if (fails < 10)
        $display("unexpected word: crossed=%0d alert=%0d count=%0d",
                 crossed, alert, in_window);
      fails++;
      return;
    end
    w = alarm_words.pop_front();
    if (crossed !== w.crossed || alert !== w.alert || in_window !== w.in_window) begin
      if (fails < 10)
        $display("word mismatch: expected crossed=%0d alert=%0d count=%0d, got %0d %0d %0d",
                 w.crossed, w.alert, w.in_window, crossed, alert, in_window);
      fails++;
    end
  endfunction

  function int unsigned pending();
    return alarm_words.size();
  endfunction
endclass

module lockout_rate_spike_detector_core_tb;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned PRESSURE_AT = 300;
  localparam int unsigned PRESSURE_LEN = 1500;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [TIME_W-1:0]     event_time_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  crossed_o;
  logic                  alert_o;
  logic [OUT_W-1:0]      events_in_window_o;

  spike_alarm_tracker tracker;
  bit                 calm = 1'b0;
  int unsigned        words_checked = 0;
  int unsigned        cycle_count = 0;
  time_t              stamp;

  lockout_rate_spike_detector_core u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .event_time_i       (event_time_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .crossed_o          (crossed_o),
    .alert_o            (alert_o),
    .events_in_window_o (events_in_window_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Mostly no pause, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  task automatic send_event(time_t t);
    int unsigned g;
    in_valid_i   <= 1'b1;
    event_time_i <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_lockout(t);
    g = pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    tracker.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic apply_setting(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] win,
                               logic [CFG_DATA_W-1:0] en);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_WINDOW, win);
    write_reg(CFG_ENABLE, en);
    cfg_we_i <= 1'b0;
  endtask

  // Event times mostly creep forward in small steps so that the count hovers
  // round the threshold; a few step back and a very few land anywhere.
  task automatic run_phase(int unsigned n, int unsigned step_max);
    int unsigned r;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 63);
      if (r == 0) begin
        send_event($urandom);
      end else begin
        if (r < 5) stamp = stamp - $urandom_range(0, 4 * step_max);
        else stamp = stamp + $urandom_range(0, step_max);
        send_event(stamp);
      end
    end
    wait_idle();
  endtask

  // Receiver: checks each word taken and stalls at random, once for a long
  // stretch so that the block backs up and refuses new events.
  initial begin
    int unsigned stall_left;
    int unsigned g;
    bit          pressure_done;
    stall_left    = 0;
    pressure_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        tracker.check_word(crossed_o, alert_o, events_in_window_o);
        words_checked++;
      end
      if (!pressure_done && words_checked >= PRESSURE_AT) begin
        stall_left    = PRESSURE_LEN;
        pressure_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          stall_left  = g - 1;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  initial begin
    time_t       edge_times [15];
    int unsigned thr;
    int unsigned win;
    tracker = new();
    edge_times = '{32'd100, 32'd101, 32'd102, 32'd102, 32'd200, 32'd0, 32'hFFFF_FFFF,
                   32'hFFFF_FFFA, 32'hFFFF_FFFB, 32'h8000_0000, 32'h7FFF_FFFF, 32'd5,
                   32'd6, 32'h5555_5555, 32'hAAAA_AAAA};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: small window and threshold, then the built-in defaults.
    apply_setting(3, 5, 1);
    foreach (edge_times[i]) send_event(edge_times[i]);
    wait_idle();
    apply_setting(0, 0, 0);
    repeat (10) send_event(32'd1000);
    wait_idle();

    stamp = $urandom_range(32'h0001_0000, 32'h7FFF_FFFF);
    apply_setting(5, 100, 1);
    run_phase(125, 40);

    calm = 1'b1;
    apply_setting(0, 0, 1);
    run_phase(125, 12);
    calm = 1'b0;

    apply_setting(2, 1, 0);
    run_phase(125, 2);

    // Times wrap past the top of the range under the widest window.
    stamp = 32'hFFFF_FF00;
    apply_setting(1023, 32'hFFFF_FFFF, 1);
    run_phase(125, 1000);

    apply_setting(RING_DEPTH, 32'hFFFF_FFFF, 1);
    run_phase(125, 50);

    thr = $urandom_range(2, 20);
    win = $urandom_range(10, 5000);
    apply_setting(thr, win, $urandom_range(0, 1));
    run_phase(125, 2 * win / thr);

    // Bits above each register's width must be dropped.
    apply_setting(32'hFFFF_FC08, 50, 32'hFFFF_FFFE);
    run_phase(125, 12);

    write_reg(CFG_SPARE, $urandom);
    apply_setting(1, 3, 32'h0000_0001);
    run_phase(125, 8);

    repeat (300) @(posedge clk_i);
    if (tracker.fails == 0 && tracker.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
